// ===== rtl/ssnk_pkg.sv =====
// ----------------------------------------------------------------------------
// ssnk_pkg: shared types and codes of the sorted-set nearest-key block
// Action and outcome codes, state codes, and the structs passed between
// the controller, the cell chain and the reduction tree.
// ----------------------------------------------------------------------------
package ssnk_pkg;

    localparam int KeyWidth = 32;

    typedef logic signed [KeyWidth-1:0] key_t;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        OUT_INSERTED  = 4'd0,
        OUT_DUPLICATE = 4'd1,
        OUT_DELETED   = 4'd2,
        OUT_ABSENT    = 4'd3,
        OUT_EXACT     = 4'd4,
        OUT_LOWER     = 4'd5,
        OUT_UPPER     = 4'd6,
        OUT_TIE       = 4'd7,
        OUT_EMPTY     = 4'd8,
        OUT_FULL      = 4'd9
    } outcome_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_SEARCH = 1'b1
    } state_t;

    typedef struct packed {
        logic ins;
        logic del;
        key_t key;
    } cell_cmd_t;

    typedef struct packed {
        logic valid;
        logic lt;
        key_t key;
    } cell_link_t;

    typedef struct packed {
        logic hit;
        logic has_lo;
        logic has_hi;
        key_t lo_key;
        key_t hi_key;
    } leaf_t;

endpackage

// ===== rtl/ssnk_if.sv =====
// ----------------------------------------------------------------------------
// ssnk_if: request and response channels
// Valid/ready channels carrying one request (action, key) and one
// response (outcome, first_key, second_key).
// ----------------------------------------------------------------------------
interface ssnk_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic signed [31:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

interface ssnk_rsp_if;
    logic              valid;
    logic              ready;
    logic [3:0]        outcome;
    logic signed [31:0] first_key;
    logic signed [31:0] second_key;

    modport source (output valid, output outcome, output first_key, output second_key,
                    input ready);
    modport sink   (input valid, input outcome, input first_key, input second_key,
                    output ready);
endinterface

// ===== rtl/ssnk_cell.sv =====
// ----------------------------------------------------------------------------
// ssnk_cell: one slot of the sorted key chain
// Holds one key, compares it with the broadcast key, flags itself as
// predecessor or successor, and shifts with its neighbors on insert/delete.
// ----------------------------------------------------------------------------
module ssnk_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssnk_pkg::cell_cmd_t    cmd,
    input  ssnk_pkg::cell_link_t   left,
    input  ssnk_pkg::cell_link_t   right,
    output ssnk_pkg::cell_link_t   link,
    output ssnk_pkg::leaf_t        leaf
);

    ssnk_pkg::key_t key_reg;
    ssnk_pkg::key_t key_next;
    logic           valid_reg;
    logic           valid_next;
    logic           lt;
    logic           eq;
    logic           is_pos;
    logic           is_pred;

    assign lt      = valid_reg && ($signed(key_reg) < $signed(cmd.key));
    assign eq      = valid_reg && (key_reg == cmd.key);
    assign is_pos  = !lt && left.lt;
    assign is_pred = lt && !right.lt;

    assign link.valid = valid_reg;
    assign link.lt    = lt;
    assign link.key   = key_reg;

    assign leaf.hit    = eq;
    assign leaf.has_lo = is_pred;
    assign leaf.has_hi = valid_reg && is_pos;
    assign leaf.lo_key = is_pred ? key_reg : '0;
    assign leaf.hi_key = (valid_reg && is_pos) ? key_reg : '0;

    always_comb
    begin
        priority if (cmd.ins && !lt)
        begin
            key_next   = is_pos ? cmd.key : left.key;
            valid_next = is_pos || left.valid;
        end
        else if (cmd.del && !lt)
        begin
            key_next   = right.key;
            valid_next = right.valid;
        end
        else
        begin
            key_next   = key_reg;
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== rtl/ssnk_tree.sv =====
// ----------------------------------------------------------------------------
// ssnk_tree: registered OR tree over the cell flags
// Collects the one-hot predecessor, successor and hit flags of all cells,
// one register level per tree level.
// ----------------------------------------------------------------------------
module ssnk_tree #(
    parameter int LEAVES = 256
) (
    input  logic            clk,
    input  ssnk_pkg::leaf_t leaf_in [LEAVES],
    output ssnk_pkg::leaf_t root
);

    localparam int Levels = $clog2(LEAVES);
    localparam int Span   = 1 << Levels;

    ssnk_pkg::leaf_t node_reg [1:2*Span-1];

    for (genvar n = 1; n < 2*Span; n++)
    begin : g_node
        if (n >= Span)
        begin : g_leaf
            if (n - Span < LEAVES)
            begin : g_used
                always_ff @(posedge clk)
                begin
                    node_reg[n] <= leaf_in[n-Span];
                end
            end
            else
            begin : g_pad
                always_ff @(posedge clk)
                begin
                    node_reg[n] <= '0;
                end
            end
        end
        else
        begin : g_inner
            always_ff @(posedge clk)
            begin
                node_reg[n] <= ssnk_pkg::leaf_t'(node_reg[2*n] | node_reg[2*n+1]);
            end
        end
    end

    assign root = node_reg[1];

endmodule

// ===== rtl/sorted_set_nearest_key.sv =====
// ----------------------------------------------------------------------------
// sorted_set_nearest_key: ordered set of signed keys with nearest lookup
// Sorted chain of key cells with insert, delete and nearest-key query.
// ----------------------------------------------------------------------------
// The set lives in a chain of CAPACITY cells kept sorted and packed from
// cell 0. Every request compares its key against all cells at once; the
// per-cell hit, predecessor and successor flags are gathered by a
// registered OR tree of clog2(CAPACITY) levels. A request with action
// insert, delete or query therefore occupies the block from acceptance
// until its response is loaded, while the flags pass the tree registers,
// so the wait before the next request grows with the tree depth; it is held longer
// only while the previous response still waits at the end of the search.
// An insert or delete shifts the chain in the cycle its response is
// loaded. Action code three is accepted without a search and gives no response.
// The response register lets a new request in while the previous
// response waits.
// ----------------------------------------------------------------------------
module sorted_set_nearest_key #(
    parameter int CAPACITY = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    ssnk_req_if.sink          req,
    ssnk_rsp_if.source        rsp
);

    localparam int Levels = $clog2(CAPACITY);
    localparam int Lat    = Levels + 1;
    localparam int CntW   = $clog2(Lat + 1);
    localparam int CountW = $clog2(CAPACITY + 1);

    ssnk_pkg::state_t    state_reg;
    ssnk_pkg::state_t    state_next;
    logic [CntW-1:0]     cnt_reg;
    logic [CntW-1:0]     cnt_next;
    ssnk_pkg::action_t   op_reg;
    ssnk_pkg::key_t      key_reg;
    logic [CountW-1:0]   key_count_reg;
    logic [CountW-1:0]   key_count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    ssnk_pkg::outcome_t  outcome_reg;
    ssnk_pkg::key_t      first_reg;
    ssnk_pkg::key_t      second_reg;

    ssnk_pkg::outcome_t  res_outcome;
    ssnk_pkg::key_t      res_first;
    ssnk_pkg::key_t      res_second;

    logic                accept;
    logic                done;
    logic                full;
    logic                empty;
    logic signed [32:0]  dlo;
    logic signed [32:0]  dhi;

    ssnk_pkg::cell_cmd_t  cmd;
    ssnk_pkg::cell_link_t links [CAPACITY];
    ssnk_pkg::leaf_t      leaves [CAPACITY];
    ssnk_pkg::leaf_t      root;
    logic [CAPACITY-1:0]  valid_vec;

    localparam ssnk_pkg::cell_link_t HeadLink = '{valid: 1'b0, lt: 1'b1, key: '0};
    localparam ssnk_pkg::cell_link_t TailLink = '{valid: 1'b0, lt: 1'b0, key: '0};

    assign req.ready = (state_reg == ssnk_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign done      = (state_reg == ssnk_pkg::ST_SEARCH) && (cnt_reg == CntW'(Lat)) &&
                       (!out_valid_reg || rsp.ready);
    assign full      = key_count_reg == CountW'(CAPACITY);
    assign empty     = key_count_reg == '0;

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ssnk_pkg::cell_link_t left_link;
        ssnk_pkg::cell_link_t right_link;

        if (i == 0)
        begin : g_head
            assign left_link = HeadLink;
        end
        else
        begin : g_mid_l
            assign left_link = links[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_link = TailLink;
        end
        else
        begin : g_mid_r
            assign right_link = links[i+1];
        end

        ssnk_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_link),
            .right (right_link),
            .link  (links[i]),
            .leaf  (leaves[i])
        );

        assign valid_vec[i] = links[i].valid;
    end

    ssnk_tree #(
        .LEAVES (CAPACITY)
    ) u_tree (
        .clk     (clk),
        .leaf_in (leaves),
        .root    (root)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            ssnk_pkg::ST_IDLE:
            begin
                if (accept && (ssnk_pkg::action_t'(req.action) != ssnk_pkg::ACT_NONE))
                begin
                    state_next = ssnk_pkg::ST_SEARCH;
                end
            end
            ssnk_pkg::ST_SEARCH:
            begin
                cnt_next = cnt_reg;
                if (cnt_reg != CntW'(Lat))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (done)
                begin
                    state_next = ssnk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssnk_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: response and chain command
    assign dlo = {key_reg[31], key_reg} - {root.lo_key[31], root.lo_key};
    assign dhi = {root.hi_key[31], root.hi_key} - {key_reg[31], key_reg};

    always_comb
    begin
        res_outcome = ssnk_pkg::OUT_EMPTY;
        res_first   = '0;
        res_second  = '0;
        cmd.ins     = 1'b0;
        cmd.del     = 1'b0;
        cmd.key     = key_reg;
        unique case (op_reg)
            ssnk_pkg::ACT_INSERT:
            begin
                res_first = key_reg;
                priority if (root.hit)
                begin
                    res_outcome = ssnk_pkg::OUT_DUPLICATE;
                end
                else if (full)
                begin
                    res_outcome = ssnk_pkg::OUT_FULL;
                end
                else
                begin
                    res_outcome = ssnk_pkg::OUT_INSERTED;
                    cmd.ins     = done;
                end
            end
            ssnk_pkg::ACT_DELETE:
            begin
                res_first = key_reg;
                if (root.hit)
                begin
                    res_outcome = ssnk_pkg::OUT_DELETED;
                    cmd.del     = done;
                end
                else
                begin
                    res_outcome = ssnk_pkg::OUT_ABSENT;
                end
            end
            ssnk_pkg::ACT_QUERY:
            begin
                priority if (empty)
                begin
                    res_outcome = ssnk_pkg::OUT_EMPTY;
                end
                else if (root.hit)
                begin
                    res_outcome = ssnk_pkg::OUT_EXACT;
                    res_first   = key_reg;
                end
                else if (root.has_lo && root.has_hi)
                begin
                    priority if (dlo == dhi)
                    begin
                        res_outcome = ssnk_pkg::OUT_TIE;
                        res_first   = root.lo_key;
                        res_second  = root.hi_key;
                    end
                    else if (dlo < dhi)
                    begin
                        res_outcome = ssnk_pkg::OUT_LOWER;
                        res_first   = root.lo_key;
                    end
                    else
                    begin
                        res_outcome = ssnk_pkg::OUT_UPPER;
                        res_first   = root.hi_key;
                    end
                end
                else if (root.has_lo)
                begin
                    res_outcome = ssnk_pkg::OUT_LOWER;
                    res_first   = root.lo_key;
                end
                else
                begin
                    res_outcome = ssnk_pkg::OUT_UPPER;
                    res_first   = root.hi_key;
                end
            end
            default:
            begin
                res_outcome = ssnk_pkg::OUT_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.ins)
        begin
            key_count_next = key_count_reg + 1'b1;
        end
        else if (cmd.del)
        begin
            key_count_next = key_count_reg - 1'b1;
        end
        else
        begin
            key_count_next = key_count_reg;
        end
    end

    always_comb
    begin
        priority if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssnk_pkg::ST_IDLE;
            cnt_reg       <= '0;
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            key_count_reg <= key_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the request, load the response
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= ssnk_pkg::action_t'(req.action);
            key_reg <= req.key;
        end
        if (done)
        begin
            outcome_reg <= res_outcome;
            first_reg   <= res_first;
            second_reg  <= res_second;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.outcome    = outcome_reg;
    assign rsp.first_key  = first_reg;
    assign rsp.second_key = second_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= CountW'(CAPACITY))
        else $error("key count above capacity");

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(key_count_reg))
        else $error("occupied cells disagree with key count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> key_count_reg == $past(key_count_reg) + 1'b1)
        else $error("insert did not grow the set");

    a_no_shift_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins || cmd.del) |-> done)
        else $error("chain shifted outside a finishing request");

    a_tie_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.outcome == ssnk_pkg::OUT_TIE)) |->
            ($signed(rsp.first_key) < $signed(rsp.second_key)))
        else $error("tie keys out of order");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted-set nearest-key block
// Drives insert, delete and nearest-key requests over the valid/ready
// request channel. Random gaps stall the sender and random stalls hold off
// the response side. A local sorted-table model predicts every response,
// and a checker compares each accepted response field by field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int SET_SIZE     = 256;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MIX_REQUESTS = 80;
    localparam int TAIL_REQUESTS = 30;
    localparam int TRIM_REQUESTS = 10;

    typedef struct packed {
        ssnk_pkg::outcome_t outcome;
        ssnk_pkg::key_t     first_key;
        ssnk_pkg::key_t     second_key;
    } set_reply_t;

    logic clk;
    logic rst_n;

    ssnk_req_if req_ch ();
    ssnk_rsp_if rsp_ch ();

    sorted_set_nearest_key #(
        .CAPACITY (SET_SIZE)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ssnk_pkg::key_t stored_keys [SET_SIZE];
    int             key_count;
    set_reply_t     expected_replies [$];
    int             mismatch_count;
    int             cycle_count;
    bit             idling_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int lower_bound_slot(input ssnk_pkg::key_t k);
        int pos;
        pos = 0;
        while (pos < key_count && stored_keys[pos] < k)
            pos++;
        return pos;
    endfunction

    function automatic bit predict_set_reply(input ssnk_pkg::action_t act,
                                             input ssnk_pkg::key_t k,
                                             output set_reply_t reply);
        int     pos;
        int     i;
        bit     found;
        longint dist_lo;
        longint dist_hi;
        reply.outcome    = ssnk_pkg::OUT_EMPTY;
        reply.first_key  = '0;
        reply.second_key = '0;
        if (act == ssnk_pkg::ACT_NONE)
            return 1'b0;
        pos   = lower_bound_slot(k);
        found = (pos < key_count) && (stored_keys[pos] == k);
        case (act)
            ssnk_pkg::ACT_INSERT:
            begin
                reply.first_key = k;
                if (found)
                    reply.outcome = ssnk_pkg::OUT_DUPLICATE;
                else if (key_count >= SET_SIZE)
                    reply.outcome = ssnk_pkg::OUT_FULL;
                else
                begin
                    for (i = key_count; i > pos; i--)
                        stored_keys[i] = stored_keys[i-1];
                    stored_keys[pos] = k;
                    key_count++;
                    reply.outcome = ssnk_pkg::OUT_INSERTED;
                end
            end
            ssnk_pkg::ACT_DELETE:
            begin
                reply.first_key = k;
                if (!found)
                    reply.outcome = ssnk_pkg::OUT_ABSENT;
                else
                begin
                    for (i = pos; i + 1 < key_count; i++)
                        stored_keys[i] = stored_keys[i+1];
                    key_count--;
                    reply.outcome = ssnk_pkg::OUT_DELETED;
                end
            end
            default:
            begin
                if (key_count == 0)
                    reply.outcome = ssnk_pkg::OUT_EMPTY;
                else if (found)
                begin
                    reply.outcome   = ssnk_pkg::OUT_EXACT;
                    reply.first_key = k;
                end
                else if (pos == 0)
                begin
                    reply.outcome   = ssnk_pkg::OUT_UPPER;
                    reply.first_key = stored_keys[0];
                end
                else if (pos == key_count)
                begin
                    reply.outcome   = ssnk_pkg::OUT_LOWER;
                    reply.first_key = stored_keys[pos-1];
                end
                else
                begin
                    dist_lo = longint'(k) - longint'(stored_keys[pos-1]);
                    dist_hi = longint'(stored_keys[pos]) - longint'(k);
                    if (dist_lo == dist_hi)
                    begin
                        reply.outcome    = ssnk_pkg::OUT_TIE;
                        reply.first_key  = stored_keys[pos-1];
                        reply.second_key = stored_keys[pos];
                    end
                    else if (dist_lo < dist_hi)
                    begin
                        reply.outcome   = ssnk_pkg::OUT_LOWER;
                        reply.first_key = stored_keys[pos-1];
                    end
                    else
                    begin
                        reply.outcome   = ssnk_pkg::OUT_UPPER;
                        reply.first_key = stored_keys[pos];
                    end
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic ssnk_pkg::key_t probe_key();
        int sel;
        int idx;
        sel = $urandom_range(0, 9);
        if (key_count > 0)
            idx = $urandom_range(0, key_count - 1);
        else
            idx = 0;
        if (sel < 4)
            return ssnk_pkg::key_t'(int'($urandom_range(0, 80)) - 40);
        if ((sel == 5 || sel == 6) && key_count > 0)
            return stored_keys[idx];
        if (sel == 7 && key_count > 0)
            return ($urandom_range(0, 1) == 1) ? stored_keys[idx] + 1 : stored_keys[idx] - 1;
        if (sel == 8)
        begin
            case ($urandom_range(0, 3))
                0: return ssnk_pkg::key_t'(32'h8000_0000);
                1: return ssnk_pkg::key_t'(32'h7fff_ffff);
                2: return ssnk_pkg::key_t'(-1);
                default: return ssnk_pkg::key_t'(0);
            endcase
        end
        return ssnk_pkg::key_t'($urandom);
    endfunction

    function automatic ssnk_pkg::key_t midpoint_key();
        int     idx;
        longint span;
        idx  = $urandom_range(0, key_count - 2);
        span = longint'(stored_keys[idx+1]) - longint'(stored_keys[idx]);
        return ssnk_pkg::key_t'(longint'(stored_keys[idx]) + span / 2);
    endfunction

    task automatic send_request(input ssnk_pkg::action_t act, input ssnk_pkg::key_t k);
        set_reply_t reply;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.key    <= k;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (predict_set_reply(act, k, reply))
            expected_replies.push_back(reply);
    endtask

    task automatic send_random_request();
        int                pick;
        ssnk_pkg::action_t act;
        ssnk_pkg::key_t    k;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            act = ssnk_pkg::ACT_NONE;
        else if (pick < 40)
            act = (key_count > 48) ? ssnk_pkg::ACT_DELETE : ssnk_pkg::ACT_INSERT;
        else if (pick < 65)
            act = ssnk_pkg::ACT_DELETE;
        else
            act = ssnk_pkg::ACT_QUERY;
        if (act == ssnk_pkg::ACT_QUERY && key_count >= 2 && $urandom_range(0, 3) == 0)
            k = midpoint_key();
        else
            k = probe_key();
        send_request(act, k);
    endtask

    task automatic test_empty_set();
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(0));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(32'h8000_0000));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(32'h7fff_ffff));
        send_request(ssnk_pkg::ACT_DELETE, ssnk_pkg::key_t'(-1));
        send_request(ssnk_pkg::ACT_NONE, ssnk_pkg::key_t'(-1));
    endtask

    task automatic test_extremes();
        send_request(ssnk_pkg::ACT_INSERT, ssnk_pkg::key_t'(32'h8000_0000));
        send_request(ssnk_pkg::ACT_INSERT, ssnk_pkg::key_t'(32'h7fff_ffff));
        send_request(ssnk_pkg::ACT_INSERT, ssnk_pkg::key_t'(0));
        send_request(ssnk_pkg::ACT_INSERT, ssnk_pkg::key_t'(32'h7fff_ffff));
        send_request(ssnk_pkg::ACT_NONE, ssnk_pkg::key_t'(32'h7fff_ffff));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(32'h8000_0000));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(32'h3fff_ffff));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(32'h4000_0000));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(32'hc000_0000));
        send_request(ssnk_pkg::ACT_DELETE, ssnk_pkg::key_t'(0));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(5));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(-5));
        send_request(ssnk_pkg::ACT_DELETE, ssnk_pkg::key_t'(32'h7fff_ffff));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(100));
        send_request(ssnk_pkg::ACT_DELETE, ssnk_pkg::key_t'(32'h8000_0000));
        send_request(ssnk_pkg::ACT_INSERT, ssnk_pkg::key_t'(10));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(-100));
        send_request(ssnk_pkg::ACT_DELETE, ssnk_pkg::key_t'(7));
        send_request(ssnk_pkg::ACT_DELETE, ssnk_pkg::key_t'(10));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(10));
    endtask

    task automatic test_full_table();
        ssnk_pkg::key_t k;
        int             pos;
        while (key_count < SET_SIZE)
            send_request(ssnk_pkg::ACT_INSERT, ssnk_pkg::key_t'($urandom));
        do
        begin
            k   = ssnk_pkg::key_t'($urandom);
            pos = lower_bound_slot(k);
        end
        while (pos < key_count && stored_keys[pos] == k);
        send_request(ssnk_pkg::ACT_INSERT, k);
        send_request(ssnk_pkg::ACT_INSERT, stored_keys[$urandom_range(0, SET_SIZE - 1)]);
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(32'h8000_0000));
        send_request(ssnk_pkg::ACT_QUERY, ssnk_pkg::key_t'(32'h7fff_ffff));
        send_request(ssnk_pkg::ACT_QUERY, midpoint_key());
        repeat (TRIM_REQUESTS)
            send_request(ssnk_pkg::ACT_DELETE, stored_keys[$urandom_range(0, key_count - 1)]);
    endtask

    task automatic test_random_mix();
        repeat (MIX_REQUESTS) send_random_request();
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        repeat (TAIL_REQUESTS) send_random_request();
    endtask

    task automatic finish_requests();
        req_ch.valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // response stalls
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%t: unexpected response, expected none, got outcome %0d",
                         $time, rsp_ch.outcome);
                mismatch_count++;
            end
            else
            begin
                if (rsp_ch.outcome !== expected_replies[0].outcome)
                begin
                    $display("%t: outcome expected %0d, got %0d", $time,
                             expected_replies[0].outcome, rsp_ch.outcome);
                    mismatch_count++;
                end
                if (rsp_ch.first_key !== expected_replies[0].first_key)
                begin
                    $display("%t: first_key expected %0d, got %0d", $time,
                             expected_replies[0].first_key, rsp_ch.first_key);
                    mismatch_count++;
                end
                if (rsp_ch.second_key !== expected_replies[0].second_key)
                begin
                    $display("%t: second_key expected %0d, got %0d", $time,
                             expected_replies[0].second_key, rsp_ch.second_key);
                    mismatch_count++;
                end
                void'(expected_replies.pop_front());
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        cycle_count    = 0;
        key_count      = 0;
        idling_on      = 1'b1;
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.action <= ssnk_pkg::ACT_NONE;
        req_ch.key    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_set();
        test_extremes();
        test_full_table();
        test_random_mix();
        test_back_to_back();
        finish_requests();
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ssnk_pkg.sv
rtl/ssnk_if.sv
rtl/ssnk_cell.sv
rtl/ssnk_tree.sv
rtl/sorted_set_nearest_key.sv
tb/sv/tb.sv
